FILE: design/fsrd_pkg.sv
package fsrd_pkg;

  // Frame store geometry
  localparam int FRAME_DEPTH = 64;
  localparam int IDX_W       = $clog2(FRAME_DEPTH);
  localparam int FILL_W      = $clog2(FRAME_DEPTH + 1);
  localparam int GRP_W       = $clog2(FRAME_DEPTH / 4 + 1);

  // Job queue geometry
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Framing characters
  localparam logic [7:0] SYNC_CHAR   = 8'h23;
  localparam logic [7:0] END_CHAR    = 8'h0D;
  localparam logic [7:0] OFFSET_CHAR = 8'h3D;
  localparam logic [7:0] RESET_CMD   = 8'h52;

  // Result status codes
  localparam logic [2:0] ST_PAYLOAD  = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_CHECKSUM = 3'd2;
  localparam logic [2:0] ST_OVERRUN  = 3'd3;
  localparam logic [2:0] ST_SHORT    = 3'd4;

  // One classified frame, handed from front to back
  typedef struct packed {
    logic [2:0]       status;
    logic [7:0]       addr;
    logic [7:0]       cmd;
    logic [GRP_W-1:0] groups;
    logic             rr;
  } job_t;

  // Frame store write port
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } wr_t;

  // Back end status towards the front end
  typedef struct packed {
    logic release_store;
  } back_stat_t;

  // Decode of one group of four offset-removed characters
  function automatic logic [7:0] dec_x(logic [7:0] a, logic [7:0] b);
    return {a[5:0], 2'b00} | {4'b0000, b[7:4]};
  endfunction

  function automatic logic [7:0] dec_y(logic [7:0] b, logic [7:0] c);
    return {b[3:0], 4'b0000} | {2'b00, c[7:2]};
  endfunction

  function automatic logic [7:0] dec_z(logic [7:0] c, logic [7:0] d);
    return {c[1:0], 6'b000000} | d;
  endfunction

endpackage

FILE: design/fsrd_front.sv
module fsrd_front import fsrd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       q_full_i,
  input  back_stat_t back_stat_i,
  output logic       push_o,
  output job_t       job_o,
  output wr_t        wr_o,
  output logic       locked_o
);

  logic [FILL_W-1:0] fill_q, fill_d;
  logic [11:0]       sum_q, sum_d;
  logic [7:0]        addr_q, addr_d;
  logic [7:0]        cmd_q, cmd_d;
  logic [7:0]        p1_q, p1_d;
  logic [7:0]        p2_q, p2_d;
  logic              lock_q, lock_d;

  logic              accept;
  logic [11:0]       sum_body;
  logic [7:0]        ck1, ck2;
  logic              ck_ok;
  logic [FILL_W-1:0] n_body;
  logic [GRP_W-1:0]  groups;

  assign in_ready_o = !q_full_i && !lock_q;
  assign accept     = in_valid_i && in_ready_o;
  assign locked_o   = lock_q;

  // Checksum over all bytes before the two checksum characters
  assign sum_body = sum_q - {4'b0000, p1_q} - {4'b0000, p2_q};
  assign ck1      = OFFSET_CHAR + {2'b00, sum_body[11:6]};
  assign ck2      = OFFSET_CHAR + {2'b00, sum_body[5:0]};
  assign ck_ok    = (ck1 == p2_q) && (ck2 == p1_q);
  assign n_body   = fill_q - FILL_W'(5);
  assign groups   = GRP_W'(n_body >> 2);

  // Classify the incoming item
  always_comb begin
    fill_d  = fill_q;
    sum_d   = sum_q;
    addr_d  = addr_q;
    cmd_d   = cmd_q;
    p1_d    = p1_q;
    p2_d    = p2_q;
    lock_d  = lock_q;
    push_o  = 1'b0;
    job_o   = '0;
    wr_o    = '0;

    if (back_stat_i.release_store) begin
      lock_d = 1'b0;
    end

    if (accept) begin
      if (fill_q == '0) begin
        if (in_byte_i == SYNC_CHAR) begin
          wr_o.en   = 1'b1;
          wr_o.addr = '0;
          wr_o.data = in_byte_i;
          sum_d     = {4'b0000, in_byte_i};
          fill_d    = FILL_W'(1);
        end
      end else if (fill_q >= FILL_W'(FRAME_DEPTH)) begin
        push_o       = 1'b1;
        job_o.status = ST_OVERRUN;
        job_o.addr   = addr_q;
        job_o.cmd    = cmd_q;
        fill_d       = '0;
      end else if (in_byte_i != END_CHAR) begin
        wr_o.en   = 1'b1;
        wr_o.addr = fill_q[IDX_W-1:0];
        wr_o.data = in_byte_i;
        sum_d     = sum_q + {4'b0000, in_byte_i};
        fill_d    = fill_q + FILL_W'(1);
        p1_d      = in_byte_i;
        p2_d      = p1_q;
        if (fill_q == FILL_W'(1)) begin
          addr_d = in_byte_i;
        end
        if (fill_q == FILL_W'(2)) begin
          cmd_d = in_byte_i;
        end
      end else begin
        push_o = 1'b1;
        fill_d = '0;
        if (fill_q < FILL_W'(5)) begin
          job_o.status = ST_SHORT;
        end else begin
          job_o.addr = addr_q;
          job_o.cmd  = cmd_q;
          if (!ck_ok) begin
            job_o.status = ST_CHECKSUM;
          end else begin
            job_o.rr = (cmd_q == RESET_CMD);
            if (groups == '0) begin
              job_o.status = ST_EMPTY;
            end else begin
              job_o.status = ST_PAYLOAD;
              job_o.groups = groups;
              lock_d       = 1'b1;
            end
          end
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      sum_q  <= '0;
      lock_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      sum_q  <= sum_d;
      lock_q <= lock_d;
    end
  end

  // Frame header and checksum tail
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    cmd_q  <= cmd_d;
    p1_q   <= p1_d;
    p2_q   <= p2_d;
  end

endmodule

FILE: design/fsrd_queue.sv
module fsrd_queue import fsrd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output job_t pop_job_o,
  output logic empty_o
);

  job_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign full_o    = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_job_o = entry_q[rd_ptr_q];

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: design/fsrd_back.sv
module fsrd_back import fsrd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  wr_t         wr_i,
  input  logic        q_empty_i,
  input  job_t        q_job_i,
  output logic        q_pop_o,
  output back_stat_t  stat_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  out_status_o,
  output logic [7:0]  out_addr_o,
  output logic [7:0]  out_cmd_o,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  output logic        out_rr_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_EMIT  = 4'b0100,
    S_STAT  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  job_t             job_q, job_d;
  logic [GRP_W-1:0] g_q, g_d;
  logic [IDX_W-1:0] p_q, p_d;
  logic [2:0]       k_q, k_d;
  logic [1:0]       j_q, j_d;
  logic [7:0]       chars_q [4];
  logic [7:0]       mem_q [FRAME_DEPTH];
  logic [7:0]       rdata_q;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             cap_en;
  logic [1:0]       cap_idx;
  logic             last_grp;
  logic             slot_free;
  logic             load;
  logic [2:0]       ld_status;
  logic [7:0]       ld_byte;
  logic             ld_last;
  logic             out_valid_q;
  logic [2:0]       status_q;
  logic [7:0]       addr_q, cmd_q, byte_q;
  logic             last_q, rr_q;

  assign slot_free = !out_valid_q || out_ready_i;
  assign last_grp  = ((g_q + GRP_W'(1)) == job_q.groups);
  assign rd_en     = (state_q == S_FETCH) && (k_q < 3'd4);
  assign rd_addr   = p_q + IDX_W'(k_q);
  assign cap_en    = (state_q == S_FETCH) && (k_q != 3'd0);
  assign cap_idx   = 2'(k_q - 3'd1);

  // Frame store: front writes, walk reads
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Collect one group with the offset removed
  always_ff @(posedge clk_i) begin
    if (cap_en) begin
      chars_q[cap_idx] <= rdata_q - OFFSET_CHAR;
    end
  end

  // Pick the decoded byte of the group
  always_comb begin
    case (j_q)
      2'd0:    ld_byte = dec_x(chars_q[0], chars_q[1]);
      2'd1:    ld_byte = dec_y(chars_q[1], chars_q[2]);
      default: ld_byte = dec_z(chars_q[2], chars_q[3]);
    endcase
  end

  // Walk the job
  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    g_d       = g_q;
    p_d       = p_q;
    k_d       = k_q;
    j_d       = j_q;
    q_pop_o   = 1'b0;
    load      = 1'b0;
    ld_status = job_q.status;
    ld_last   = 1'b0;
    stat_o    = '0;

    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          job_d   = q_job_i;
          g_d     = '0;
          p_d     = IDX_W'(3);
          k_d     = '0;
          j_d     = '0;
          state_d = (q_job_i.status == ST_PAYLOAD) ? S_FETCH : S_STAT;
        end
      end
      S_FETCH: begin
        k_d = k_q + 3'd1;
        if (k_q == 3'd4) begin
          k_d     = '0;
          j_d     = '0;
          state_d = S_EMIT;
          stat_o.release_store = last_grp;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          load      = 1'b1;
          ld_status = ST_PAYLOAD;
          ld_last   = (j_q == 2'd2) && last_grp;
          j_d       = j_q + 2'd1;
          if (j_q == 2'd2) begin
            if (last_grp) begin
              state_d = S_IDLE;
            end else begin
              g_d     = g_q + GRP_W'(1);
              p_d     = p_q + IDX_W'(4);
              state_d = S_FETCH;
            end
          end
        end
      end
      S_STAT: begin
        if (slot_free) begin
          load    = 1'b1;
          ld_last = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Job registers and output slot
  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    g_q   <= g_d;
    p_q   <= p_d;
    k_q   <= k_d;
    j_q   <= j_d;
    if (load) begin
      status_q <= ld_status;
      addr_q   <= job_q.addr;
      cmd_q    <= job_q.cmd;
      byte_q   <= (ld_status == ST_PAYLOAD) ? ld_byte : 8'h00;
      last_q   <= ld_last;
      rr_q     <= job_q.rr;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = status_q;
  assign out_addr_o   = addr_q;
  assign out_cmd_o    = cmd_q;
  assign out_byte_o   = byte_q;
  assign out_last_o   = last_q;
  assign out_rr_o     = rr_q;

endmodule

FILE: design/framed_serial_receiver_decoder_top.sv
// A status result passes the job queue and the back end's status state to the output
//   register; a payload byte of a frame first has its group read from the store.
// Throughput: one item per cycle while a frame is gathered and the job queue is not full;
//   after a frame with payload the input stalls until its last group is read from the store.
// Reset: asynchronous, active low; the receiver waits for sync, the job queue and the
//   output slot are empty. The frame store is not cleared; it is written before it is read.
module framed_serial_receiver_decoder_top import fsrd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] address_char, [15:8] command_char,
                                      // [23:16] payload_byte
  output logic        m_axis_tlast,   // last
  output logic [3:0]  m_axis_tuser    // [2:0] status, [3] reset_request
);

  logic       push, q_full, q_empty, q_pop, locked;
  job_t       push_job, pop_job;
  wr_t        wr;
  back_stat_t back_stat;
  logic [2:0] status;
  logic [7:0] addr, cmd, pbyte;
  logic       rr;

  fsrd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .q_full_i    (q_full),
    .back_stat_i (back_stat),
    .push_o      (push),
    .job_o       (push_job),
    .wr_o        (wr),
    .locked_o    (locked)
  );

  fsrd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .pop_job_o  (pop_job),
    .empty_o    (q_empty)
  );

  fsrd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (wr),
    .q_empty_i    (q_empty),
    .q_job_i      (pop_job),
    .q_pop_o      (q_pop),
    .stat_o       (back_stat),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (status),
    .out_addr_o   (addr),
    .out_cmd_o    (cmd),
    .out_byte_o   (pbyte),
    .out_last_o   (m_axis_tlast),
    .out_rr_o     (rr)
  );

  assign m_axis_tdata = {pbyte, cmd, addr};
  assign m_axis_tuser = {rr, status};

`ifndef NO_ASSERTIONS
  // No frame byte may land in the store while the walk still reads it
  assert property (@(posedge clk_i) disable iff (!rst_ni) locked |-> !wr.en)
    else $error("frame store written during decode walk");

  // The front never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_full)
    else $error("job pushed into full queue");

  // Release of the store only comes while the front holds it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.release_store |-> locked)
    else $error("store released without a pending decode");

  // Every status result is the only one of its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser[2:0] != ST_PAYLOAD)) |-> m_axis_tlast)
    else $error("status result without last marker");
`endif

endmodule
